/* rtl/srt_pkg.sv */
// Shared types and codes for the segment region translation block.
`timescale 1ns / 1ps
`default_nettype none

package srt_pkg;

  // Item function codes
  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  typedef enum logic [2:0] {
    STAT_FOUND = 3'd0,
    STAT_NMAP  = 3'd1,
    STAT_NMEM  = 3'd2,
    STAT_NDUMP = 3'd3,
    STAT_WACK  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH,
    S_DONE
  } eng_state_t;

  // One table entry as stored in the RAM
  typedef struct packed {
    logic [31:0] start;
    logic [31:0] mem_size;
    logic [31:0] file_size;
    logic [31:0] file_offset;
    logic        load;
    logic        ex;
    logic        wr;
  } seg_entry_t;

  typedef struct packed {
    status_t     status;
    logic [3:0]  seg;
    logic [31:0] off;
    logic        ex;
    logic        wr;
  } result_t;

endpackage

`default_nettype wire

/* rtl/srt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module srt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

/* rtl/srt_lookup.sv */
// Table scan engine: streams entries out of the RAM, matches, builds the result.
`timescale 1ns / 1ps
`default_nettype none

module srt_lookup import srt_pkg::*; #(
  parameter int unsigned MAX_SEGMENTS = 16,
  localparam int unsigned IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1,
  localparam int unsigned LIM_W = $clog2(MAX_SEGMENTS + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic             start_func,
  input  wire logic [31:0]      start_addr,
  input  wire logic [4:0]       seg_count,
  output logic                  ready,
  output logic                  rd_en,
  output logic      [IDX_W-1:0] rd_addr,
  input  wire seg_entry_t       rd_data,
  output logic                  res_valid,
  input  wire logic             res_take,
  output result_t               res
);

  eng_state_t       state_r, state_nxt;
  logic [LIM_W-1:0] limit_r, rd_ptr_r, limit_in;
  logic             chk_vld_r;
  logic [IDX_W-1:0] chk_idx_r, hit_idx_r;
  logic [31:0]      addr_r, diff_r, seg_end, fo_sum;
  seg_entry_t       hit_r;
  result_t          res_r;
  logic             more, match;

  // clamp the search length to the table depth
  assign limit_in = (32'(seg_count) > MAX_SEGMENTS) ? LIM_W'(MAX_SEGMENTS)
                                                     : LIM_W'(seg_count);
  assign more     = rd_ptr_r < limit_r;
  assign seg_end  = rd_data.start + rd_data.mem_size;
  assign match    = chk_vld_r && rd_data.load &&
                    (addr_r >= rd_data.start) && (addr_r < seg_end);
  assign fo_sum   = hit_r.file_offset + diff_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = (start_func == FUNC_WRITE) ? S_DONE : S_SCAN;
        end
      end
      S_SCAN: begin
        if (match) begin
          state_nxt = S_FINISH;
        end else if (!more) begin
          state_nxt = S_DONE;
        end
      end
      S_FINISH: state_nxt = S_DONE;
      S_DONE: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ready     = (state_r == S_IDLE);
    rd_en     = (state_r == S_SCAN) && more;
    res_valid = (state_r == S_DONE);
    rd_addr   = rd_ptr_r[IDX_W-1:0];
  end

  assign res = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      chk_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      chk_vld_r <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_IDLE) && start) begin
      addr_r   <= start_addr;
      limit_r  <= limit_in;
      rd_ptr_r <= '0;
    end else if (rd_en) begin
      rd_ptr_r <= rd_ptr_r + LIM_W'(1);
    end

    if (rd_en) begin
      chk_idx_r <= rd_addr;
    end

    if ((state_r == S_SCAN) && match) begin
      hit_r     <= rd_data;
      hit_idx_r <= chk_idx_r;
      diff_r    <= addr_r - rd_data.start;
    end

    if ((state_r == S_IDLE) && start) begin
      res_r.status <= STAT_WACK;
      res_r.seg    <= '0;
      res_r.off    <= '0;
      res_r.ex     <= 1'b0;
      res_r.wr     <= 1'b0;
    end else if ((state_r == S_SCAN) && !match && !more) begin
      res_r.status <= STAT_NMAP;
      res_r.seg    <= '0;
      res_r.off    <= '0;
      res_r.ex     <= 1'b0;
      res_r.wr     <= 1'b0;
    end else if (state_r == S_FINISH) begin
      res_r.seg <= 4'(hit_idx_r);
      res_r.ex  <= hit_r.ex;
      res_r.wr  <= hit_r.wr;
      if (hit_r.mem_size == '0) begin
        res_r.status <= STAT_NMEM;
        res_r.off    <= '0;
      end else if (hit_r.mem_size != hit_r.file_size) begin
        res_r.status <= STAT_NDUMP;
        res_r.off    <= '0;
      end else begin
        res_r.status <= STAT_FOUND;
        res_r.off    <= fo_sum;
      end
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> (state_r == S_IDLE))
    else $error("scan start while engine busy");

  a_data_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    chk_vld_r |-> ((state_r == S_SCAN) || (state_r == S_FINISH)))
    else $error("RAM read data returned outside a scan");

  a_hit_finish: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_SCAN) && match) |=> ((state_r == S_FINISH) && $stable(addr_r)))
    else $error("hit did not move to finish");

  a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && !res_take) |=> (res_valid && $stable(res_r)))
    else $error("pending result lost or changed");

endmodule

`default_nettype wire

/* rtl/segment_region_translate.sv */
// Top level of the segment region translation block.
`timescale 1ns / 1ps
`default_nettype none

// Translates 32-bit virtual addresses to file offsets through a table of up to
// MAX_SEGMENTS segment descriptors kept in one RAM with a registered read port.
// A write transaction (func 0) stores one descriptor at entry_index (indexes at
// or above MAX_SEGMENTS are dropped but still acknowledged with status 4). A
// lookup transaction (func 1) scans entries 0 .. segment_count-1 (clamped to
// MAX_SEGMENTS), one RAM read per cycle, and reports the lowest loadable entry
// with start <= address < start + mem_size (32-bit wrapped end): found with the
// translated offset, not dumped when the memory and file sizes differ, or not
// mapped. A write goes from idle straight to done; a lookup passes through the
// scan state, and on a hit the finish state, before done. The scan is paced by
// the single RAM read port that feeds the compare one entry per cycle. The input
// channel is held off while an item is in flight; a finished result sits in the
// output register and a new transaction can be accepted while it waits. Table
// entries read before ever being written return undefined data. The user must
// write segment_count through the cfg channel only while the block is idle; the
// block itself does not enforce this, and cfg_ready is always high.

module segment_region_translate import srt_pkg::*; #(
  parameter int unsigned MAX_SEGMENTS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // item channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_func,
  input  wire logic [3:0]  in_entry_index,
  input  wire logic [31:0] in_entry_start,
  input  wire logic [31:0] in_entry_mem_size,
  input  wire logic [31:0] in_entry_file_size,
  input  wire logic [31:0] in_entry_file_offset,
  input  wire logic        in_entry_loadable,
  input  wire logic        in_entry_exec,
  input  wire logic        in_entry_write,
  input  wire logic [31:0] in_lookup_address,
  // result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_status,
  output logic [3:0]       out_segment_found,
  output logic [31:0]      out_file_offset,
  output logic             out_is_executable,
  output logic             out_is_writable,
  // configuration
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [4:0]  cfg_segment_count
);

  localparam int unsigned IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;

  logic             in_acc;
  logic [4:0]       count_r;
  logic             ram_we;
  seg_entry_t       wr_entry;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  seg_entry_t       rd_data;
  logic             eng_ready, eng_res_valid, res_take;
  result_t          eng_res;
  logic             out_valid_r;
  result_t          out_res_r;

  assign in_acc    = in_valid && in_ready;
  assign in_ready  = eng_ready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      count_r <= cfg_segment_count;
    end
  end

  // Table writes land at accept time; the engine is idle then, so a write
  // never overlaps a scan read of the same entry.
  assign ram_we = in_acc && (in_func == FUNC_WRITE) &&
                  (32'(in_entry_index) < MAX_SEGMENTS);

  always_comb begin
    wr_entry.start       = in_entry_start;
    wr_entry.mem_size    = in_entry_mem_size;
    wr_entry.file_size   = in_entry_file_size;
    wr_entry.file_offset = in_entry_file_offset;
    wr_entry.load        = in_entry_loadable;
    wr_entry.ex          = in_entry_exec;
    wr_entry.wr          = in_entry_write;
  end

  srt_ram #(
    .WIDTH ($bits(seg_entry_t)),
    .DEPTH (MAX_SEGMENTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (IDX_W'(in_entry_index)),
    .wdata (wr_entry),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  srt_lookup #(
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_lookup (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (in_acc),
    .start_func (in_func),
    .start_addr (in_lookup_address),
    .seg_count  (count_r),
    .ready      (eng_ready),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .res_valid  (eng_res_valid),
    .res_take   (res_take),
    .res        (eng_res)
  );

  // Output register: takes the engine result when empty or being drained.
  assign res_take = eng_res_valid && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_res_r <= eng_res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_res_r.status;
  assign out_segment_found = out_res_r.seg;
  assign out_file_offset   = out_res_r.off;
  assign out_is_executable = out_res_r.ex;
  assign out_is_writable   = out_res_r.wr;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("second transaction accepted while first in flight");

endmodule

`default_nettype wire
